// ===== src/skt_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the sorted key table.
`default_nettype none
package skt_pkg;

  localparam int unsigned DEPTH      = 256;
  localparam int unsigned KEY_WIDTH  = 32;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned ENTRY_W    = KEY_WIDTH + DATA_WIDTH;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_DELETE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BS_CHK,
    S_BS_CMP,
    S_HIT,
    S_UP,
    S_PLACE,
    S_DN,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic    load;
    logic    rd_mid;
    logic    bs_step;
    logic    rd_lo;
    logic    set_res;
    status_e res_code;
    logic    res_cap;
    logic    start_up;
    logic    shift_up;
    logic    place;
    logic    start_dn;
    logic    shift_dn;
    logic    dec_count;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       lo_lt_hi;
    logic       hit;
    logic       full;
    logic       up_needed;
    logic       del_more;
    logic       ptr_at_p;
    logic       ptr_at_last;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/sorted_key_table_top.sv =====
// Top level of the sorted key table: controller and datapath joined by command and status.
//
// The block keeps up to DEPTH key/data entries in ascending key order in one RAM.
// Requests arrive on the input channel (in_valid_i/in_ready_o with kind_i, key_i,
// data_i); each request gives exactly one result on the output channel
// (out_valid_o/out_ready_i with status_o, position_o, found_data_o, entry_count_o).
// A transfer happens on a rising edge with valid and ready both high.
// The block works on one request at a time. Each binary search step is one RAM read
// followed by one compare. Insert then moves the larger entries up one per cycle
// through the RAM's single write port and then writes the new entry; delete moves
// them down one per cycle. At DEPTH = 256 the slowest request is a delete of the
// smallest of 256 entries; the next request can be taken in the cycle after the
// result has been loaded.
// The result waits in an output register, so the next request is taken while
// an earlier result is still held; if the receiver stalls, the new request runs
// to its end and then waits until the held result has been taken.
// Reset empties the table (count zero), clears signed_keys and drops any held
// result; the RAM needs no clearing since only entries below the count are read.
// cfg_we_i writes signed_keys from cfg_data_i and should only be used when idle.
`default_nettype none
module sorted_key_table_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [31:0] key_i,
  input  wire logic [31:0] data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [7:0]       position_o,
  output logic [31:0]      found_data_o,
  output logic [8:0]       entry_count_o
);

  // Commands from the controller and status back from the datapath.
  skt_pkg::cmd_t cmd;
  skt_pkg::sts_t sts;

  skt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  skt_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .kind_i       (kind_i),
    .key_i        (key_i),
    .data_i       (data_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .position_o   (position_o),
    .found_data_o (found_data_o),
    .entry_count_o(entry_count_o)
  );

endmodule
`default_nettype wire

// ===== src/skt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module skt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/skt_ctrl.sv =====
// Controller state machine sequencing search, shift and result phases of the table.
`default_nettype none
module skt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire skt_pkg::sts_t sts_i,
  output skt_pkg::cmd_t      cmd_o
);

  skt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.res_code = skt_pkg::ST_MISSING;
    in_ready_o = 1'b0;
    unique case (state_q)
      skt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = skt_pkg::S_BS_CHK;
        end
      end
      skt_pkg::S_BS_CHK: begin
        if (sts_i.lo_lt_hi) begin
          cmd_o.rd_mid = 1'b1;
          state_d      = skt_pkg::S_BS_CMP;
        end else begin
          cmd_o.rd_lo = 1'b1;
          state_d     = skt_pkg::S_HIT;
        end
      end
      skt_pkg::S_BS_CMP: begin
        cmd_o.bs_step = 1'b1;
        state_d       = skt_pkg::S_BS_CHK;
      end
      skt_pkg::S_HIT: begin
        cmd_o.set_res = 1'b1;
        state_d       = skt_pkg::S_RESULT;
        unique case (sts_i.kind)
          skt_pkg::KIND_INSERT: begin
            if (sts_i.full) begin
              cmd_o.res_code = skt_pkg::ST_FULL;
            end else if (sts_i.hit) begin
              cmd_o.res_code = skt_pkg::ST_DUP;
            end else begin
              cmd_o.res_code = skt_pkg::ST_OK;
              if (sts_i.up_needed) begin
                cmd_o.start_up = 1'b1;
                state_d        = skt_pkg::S_UP;
              end else begin
                state_d = skt_pkg::S_PLACE;
              end
            end
          end
          skt_pkg::KIND_SEARCH: begin
            if (sts_i.hit) begin
              cmd_o.res_code = skt_pkg::ST_OK;
              cmd_o.res_cap  = 1'b1;
            end
          end
          skt_pkg::KIND_DELETE: begin
            if (sts_i.hit) begin
              cmd_o.res_code = skt_pkg::ST_OK;
              cmd_o.res_cap  = 1'b1;
              if (sts_i.del_more) begin
                cmd_o.start_dn = 1'b1;
                state_d        = skt_pkg::S_DN;
              end else begin
                cmd_o.dec_count = 1'b1;
              end
            end
          end
          default: begin
            cmd_o.res_code = skt_pkg::ST_MISSING;
          end
        endcase
      end
      skt_pkg::S_UP: begin
        cmd_o.shift_up = 1'b1;
        if (sts_i.ptr_at_p) begin
          state_d = skt_pkg::S_PLACE;
        end
      end
      skt_pkg::S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = skt_pkg::S_RESULT;
      end
      skt_pkg::S_DN: begin
        cmd_o.shift_dn = 1'b1;
        if (sts_i.ptr_at_last) begin
          cmd_o.dec_count = 1'b1;
          state_d         = skt_pkg::S_RESULT;
        end
      end
      skt_pkg::S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = skt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = skt_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/skt_dp.sv =====
// Datapath of the table: request registers, search bounds, entry RAM, shifter and result register.
`default_nettype none
module skt_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_data_i,
  input  wire logic [1:0]                     kind_i,
  input  wire logic [31:0]                    key_i,
  input  wire logic [31:0]                    data_i,
  input  wire skt_pkg::cmd_t                  cmd_i,
  output skt_pkg::sts_t                       sts_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [1:0]                          status_o,
  output logic [7:0]                          position_o,
  output logic [31:0]                         found_data_o,
  output logic [8:0]                          entry_count_o
);

  localparam int unsigned KW = skt_pkg::KEY_WIDTH;
  localparam int unsigned DW = skt_pkg::DATA_WIDTH;
  localparam int unsigned AW = skt_pkg::ADDR_W;
  localparam int unsigned CW = skt_pkg::CNT_W;
  localparam int unsigned EW = skt_pkg::ENTRY_W;

  logic          signed_q;
  logic [CW-1:0] count_q, lo_q, hi_q;
  logic [AW-1:0] ptr_q;
  logic          out_valid_q;
  logic [1:0]    kind_q;
  logic [KW-1:0] key_q;
  logic [DW-1:0] data_q;
  skt_pkg::status_e res_q;
  logic [DW-1:0] fdata_q;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic [KW-1:0] rkey, sign_mask;
  logic [DW-1:0] rdata_data;
  logic [CW-1:0] mid, cnt_m1, ptr_ext;
  logic [AW-1:0] p_addr;
  logic          lt;

  skt_ram #(
    .WIDTH(EW),
    .DEPTH(skt_pkg::DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rkey       = ram_rdata[EW-1:DW];
  assign rdata_data = ram_rdata[DW-1:0];
  assign sign_mask  = KW'(signed_q) << (KW - 1);
  assign lt         = (rkey ^ sign_mask) < (key_q ^ sign_mask);
  assign mid        = lo_q + ((hi_q - lo_q) >> 1);
  assign cnt_m1     = count_q - CW'(1);
  assign p_addr     = lo_q[AW-1:0];
  assign ptr_ext    = CW'(ptr_q);

  always_comb begin
    sts_o             = '0;
    sts_o.kind        = kind_q;
    sts_o.lo_lt_hi    = lo_q < hi_q;
    sts_o.hit         = (lo_q < count_q) && (rkey == key_q);
    sts_o.full        = count_q == CW'(skt_pkg::DEPTH);
    sts_o.up_needed   = count_q > lo_q;
    sts_o.del_more    = (lo_q + CW'(1)) < count_q;
    sts_o.ptr_at_p    = ptr_q == p_addr;
    sts_o.ptr_at_last = (ptr_ext + CW'(1)) == count_q;
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    if (cmd_i.rd_mid) begin
      ram_re    = 1'b1;
      ram_raddr = mid[AW-1:0];
    end
    if (cmd_i.rd_lo) begin
      ram_re    = 1'b1;
      ram_raddr = p_addr;
    end
    if (cmd_i.start_up) begin
      ram_re    = 1'b1;
      ram_raddr = cnt_m1[AW-1:0];
    end
    if (cmd_i.start_dn) begin
      ram_re    = 1'b1;
      ram_raddr = p_addr + AW'(1);
    end
    if (cmd_i.shift_up) begin
      ram_we    = 1'b1;
      ram_waddr = ptr_q + AW'(1);
      ram_re    = !sts_o.ptr_at_p;
      ram_raddr = ptr_q - AW'(1);
    end
    if (cmd_i.shift_dn) begin
      ram_we    = 1'b1;
      ram_waddr = ptr_q - AW'(1);
      ram_re    = !sts_o.ptr_at_last;
      ram_raddr = ptr_q + AW'(1);
    end
    if (cmd_i.place) begin
      ram_we    = 1'b1;
      ram_waddr = p_addr;
      ram_wdata = {key_q, data_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_q    <= 1'b0;
      count_q     <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        signed_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        lo_q <= '0;
        hi_q <= count_q;
      end
      if (cmd_i.bs_step) begin
        if (lt) begin
          lo_q <= mid + CW'(1);
        end else begin
          hi_q <= mid;
        end
      end
      if (cmd_i.start_up) begin
        ptr_q <= cnt_m1[AW-1:0];
      end
      if (cmd_i.shift_up) begin
        ptr_q <= ptr_q - AW'(1);
      end
      if (cmd_i.start_dn) begin
        ptr_q <= p_addr + AW'(1);
      end
      if (cmd_i.shift_dn) begin
        ptr_q <= ptr_q + AW'(1);
      end
      if (cmd_i.place) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.dec_count) begin
        count_q <= cnt_m1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      key_q  <= KW'(key_i);
      data_q <= DW'(data_i);
    end
    if (cmd_i.set_res) begin
      res_q   <= cmd_i.res_code;
      fdata_q <= cmd_i.res_cap ? rdata_data : '0;
    end
    if (cmd_i.out_load) begin
      status_o      <= res_q;
      position_o    <= (res_q == skt_pkg::ST_OK) ? 8'(lo_q) : 8'd0;
      found_data_o  <= 32'(fdata_q);
      entry_count_o <= 9'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(skt_pkg::DEPTH))
    else $error("entry count exceeds table depth");

  a_bounds_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q <= hi_q)
    else $error("search bounds crossed");

  a_place_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.place |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not grow the entry count");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_i.out_load)
    else $error("held result overwritten");

endmodule
`default_nettype wire

// ===== tb/sorted_key_table_top_tb.sv =====
// Self-checking testbench of the sorted key table: directed and random requests against a behavioural table.
module sorted_key_table_top_tb;

  // Kind code with no meaning; the block must answer it as a miss and leave the table alone.
  localparam logic [1:0]  KIND_UNUSED      = 2'd3;
  localparam logic [31:0] SIGN_BIT         = 32'h8000_0000;
  localparam int unsigned GAP_MAX          = 5;
  // The receiver holds off once, for a long stretch, when it has taken this many results.
  localparam int unsigned LONG_HOLD_AT     = 450;
  localparam int unsigned LONG_HOLD_CYCLES = 600;
  // The limit lies above the slowest item plus both sides' gaps, and above the long hold.
  localparam int unsigned STALL_LIMIT      = 5000;
  localparam int unsigned TAIL_CYCLES      = 300;
  localparam int unsigned ERR_SHOWN        = 10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] data;
  } request_t;

  typedef struct packed {
    skt_pkg::status_e status;
    logic [7:0]       position;
    logic [31:0]      found_data;
    logic [8:0]       entry_count;
  } answer_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_data_i  = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [1:0]  kind_i      = '0;
  logic [31:0] key_i       = '0;
  logic [31:0] data_i      = '0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic [7:0]  position_o;
  logic [31:0] found_data_o;
  logic [8:0]  entry_count_o;

  sorted_key_table_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .key_i         (key_i),
    .data_i        (data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .position_o    (position_o),
    .found_data_o  (found_data_o),
    .entry_count_o (entry_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Behavioural copy of the table: keys and payloads in the order the block keeps them,
  // the entry count and the comparison mode currently set.
  logic [31:0]  tbl_key  [skt_pkg::DEPTH];
  logic [31:0]  tbl_data [skt_pkg::DEPTH];
  int unsigned  tbl_count  = 0;
  logic         signed_cmp = 1'b0;

  request_t     pending_reqs[$];
  answer_t      due_answers[$];
  logic [31:0]  key_pool[$];
  int unsigned  n_issued     = 0;
  int unsigned  n_taken      = 0;
  int unsigned  n_bad        = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  tx_gap       = 0;
  int unsigned  rx_wait      = 0;
  int unsigned  rx_items     = 0;
  logic         in_fire      = 1'b0;
  logic         out_fire     = 1'b0;

  // Flipping the sign bit lets an unsigned comparison give the signed order.
  function automatic logic [31:0] order_of(logic [31:0] k);
    return signed_cmp ? (k ^ SIGN_BIT) : k;
  endfunction

  // Applies one request to the behavioural table and returns the answer the block must give.
  // The position is found by a binary search for the first key not below the request's key.
  function automatic answer_t apply_to_table(request_t r);
    answer_t     a;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned i;
    logic        hit;
    a.status     = skt_pkg::ST_MISSING;
    a.position   = '0;
    a.found_data = '0;
    lo = 0;
    hi = tbl_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (order_of(tbl_key[mid]) < order_of(r.key)) lo = mid + 1;
      else hi = mid;
    end
    hit = (lo < tbl_count) && (tbl_key[lo] == r.key);
    case (r.kind)
      skt_pkg::KIND_INSERT: begin
        // A full table is reported before a duplicate key.
        if (tbl_count >= skt_pkg::DEPTH) a.status = skt_pkg::ST_FULL;
        else if (hit) a.status = skt_pkg::ST_DUP;
        else begin
          for (i = tbl_count; i > lo; i--) begin
            tbl_key[i]  = tbl_key[i - 1];
            tbl_data[i] = tbl_data[i - 1];
          end
          tbl_key[lo]  = r.key;
          tbl_data[lo] = r.data;
          tbl_count++;
          a.status   = skt_pkg::ST_OK;
          a.position = 8'(lo);
        end
      end
      skt_pkg::KIND_SEARCH: begin
        if (hit) begin
          a.status     = skt_pkg::ST_OK;
          a.position   = 8'(lo);
          a.found_data = tbl_data[lo];
        end
      end
      skt_pkg::KIND_DELETE: begin
        if (hit) begin
          a.status     = skt_pkg::ST_OK;
          a.position   = 8'(lo);
          a.found_data = tbl_data[lo];
          for (i = lo; i + 1 < tbl_count; i++) begin
            tbl_key[i]  = tbl_key[i + 1];
            tbl_data[i] = tbl_data[i + 1];
          end
          tbl_count--;
        end
      end
      default: begin
      end
    endcase
    a.entry_count = 9'(tbl_count);
    return a;
  endfunction

  // Idle cycles before an item or a result; every third stretch of forty runs without idling.
  function automatic int unsigned draw_gap(int unsigned n);
    if ((n / 40) % 3 == 0) return 0;
    return $urandom_range(0, GAP_MAX);
  endfunction

  // Sampling side. Transfers on both channels are seen at the rising edge. The result
  // transfer is handled before the request transfer, so a result can never be matched
  // against the answer of a request taken at the same edge.
  always @(posedge clk_i) begin : check_results
    request_t got;
    answer_t  want;
    in_fire  = rst_ni && in_valid_i && in_ready_o;
    out_fire = rst_ni && out_valid_o && out_ready_i;
    if (out_fire) begin
      if (due_answers.size() == 0) begin
        n_bad++;
        if (n_bad <= ERR_SHOWN)
          $display("unexpected result: status %0d position %0d data %h count %0d",
                   status_o, position_o, found_data_o, entry_count_o);
      end else begin
        want = due_answers.pop_front();
        if (want.status !== status_o || want.position !== position_o ||
            want.found_data !== found_data_o || want.entry_count !== entry_count_o) begin
          n_bad++;
          if (n_bad <= ERR_SHOWN)
            $display({"result mismatch: expected status %0d position %0d data %h count %0d,",
                      " got status %0d position %0d data %h count %0d"},
                     want.status, want.position, want.found_data, want.entry_count,
                     status_o, position_o, found_data_o, entry_count_o);
        end
      end
    end
    if (in_fire) begin
      got.kind = kind_i;
      got.key  = key_i;
      got.data = data_i;
      due_answers.push_back(apply_to_table(got));
      n_taken++;
    end
    // Watchdog: a long run of cycles without any transfer means the block has hung.
    if (in_fire || out_fire) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("sorted_key_table_top: mismatch");
      $finish;
    end
  end

  // Request driver. It changes the inputs at the falling edge, keeps valid and the payload
  // steady until the transfer, and waits a drawn number of cycles before each new item.
  always @(negedge clk_i) begin : drive_requests
    request_t nxt;
    if (rst_ni) begin
      if (in_fire) tx_gap = draw_gap(n_taken);
      if (!in_valid_i || in_fire) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          kind_i     <= nxt.kind;
          key_i      <= nxt.key;
          data_i     <= nxt.data;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result receiver. After each transfer it draws a short stall; once in the run it holds
  // off for a long stretch so that the block fills up and stops taking requests.
  always @(negedge clk_i) begin : drive_ready
    if (rst_ni) begin
      if (out_fire) begin
        rx_items++;
        rx_wait = (rx_items == LONG_HOLD_AT) ? LONG_HOLD_CYCLES : draw_gap(rx_items);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic add_request(logic [1:0] k, logic [31:0] key, logic [31:0] data);
    request_t r;
    r.kind = k;
    r.key  = key;
    r.data = data;
    pending_reqs.push_back(r);
    n_issued++;
  endtask

  // Waits until every queued request has been taken and every answer has arrived.
  task automatic settle();
    while (n_taken != n_issued || due_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // The mode register is only written while the block is idle.
  task automatic write_signed_cfg(logic v);
    @(negedge clk_i);
    cfg_data_i = v;
    cfg_we_i   = 1'b1;
    @(posedge clk_i);
    signed_cmp = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [31:0] rand_data();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // New keys are either spread over the whole range or clustered around the points where
  // signed and unsigned order disagree, so that both comparisons are stressed.
  function automatic logic [31:0] fresh_key(bit clustered);
    logic [31:0] anchor;
    case ($urandom_range(0, 3))
      0:       anchor = 32'h0000_0000;
      1:       anchor = 32'h7FFF_FFFF;
      2:       anchor = 32'h8000_0000;
      default: anchor = 32'hFFFF_FFFF;
    endcase
    if (clustered) return anchor + 32'($urandom_range(0, 16)) - 32'd8;
    if ($urandom_range(0, 7) == 0) return anchor;
    return $urandom();
  endfunction

  // A run of random requests. Searches and deletes mostly name keys known to be stored,
  // and a few inserts repeat a stored key to provoke the duplicate answer.
  task automatic run_mix(int unsigned n, int unsigned ins_pct, int unsigned srch_pct,
                         int unsigned del_pct, bit clustered);
    int unsigned j;
    int unsigned r;
    int unsigned i;
    logic [31:0] k;
    logic [1:0]  kd;
    settle();
    key_pool.delete();
    for (i = 0; i < tbl_count; i++) key_pool.push_back(tbl_key[i]);
    for (j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct) begin
        if (key_pool.size() > 0 && $urandom_range(0, 9) == 0) begin
          k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end else begin
          k = fresh_key(clustered);
          key_pool.push_back(k);
        end
        add_request(skt_pkg::KIND_INSERT, k, rand_data());
      end else begin
        if (key_pool.size() > 0 && $urandom_range(0, 9) < 7)
          k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else
          k = fresh_key(clustered);
        if (r < ins_pct + srch_pct) kd = skt_pkg::KIND_SEARCH;
        else if (r < ins_pct + srch_pct + del_pct) kd = skt_pkg::KIND_DELETE;
        else kd = KIND_UNUSED;
        add_request(kd, k, rand_data());
      end
    end
  endtask

  // Deletes every stored entry in random order, leaving the table empty.
  task automatic empty_table();
    logic [31:0] left[$];
    int unsigned i;
    int unsigned idx;
    settle();
    for (i = 0; i < tbl_count; i++) left.push_back(tbl_key[i]);
    while (left.size() > 0) begin
      idx = $urandom_range(0, left.size() - 1);
      add_request(skt_pkg::KIND_DELETE, left[idx], rand_data());
      left.delete(idx);
    end
    settle();
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    write_signed_cfg(1'b0);

    // Directed part with unsigned keys: misses on an empty table, the key and payload
    // extremes, a duplicate, searches at both ends, the unused kind and deletes at the
    // first, middle and last positions.
    add_request(skt_pkg::KIND_SEARCH, 32'h0000_0005, 32'hFFFF_FFFF);
    add_request(skt_pkg::KIND_DELETE, 32'h0000_0005, 32'h0000_0000);
    add_request(KIND_UNUSED,          32'h0000_0000, 32'h0000_0000);
    add_request(skt_pkg::KIND_INSERT, 32'h0000_0000, 32'h0000_0000);
    add_request(skt_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_request(skt_pkg::KIND_INSERT, 32'h8000_0000, 32'h5A5A_5A5A);
    add_request(skt_pkg::KIND_INSERT, 32'h7FFF_FFFF, 32'hA5A5_A5A5);
    add_request(skt_pkg::KIND_INSERT, 32'h7FFF_FFFF, 32'h1234_5678);
    add_request(skt_pkg::KIND_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF);
    add_request(skt_pkg::KIND_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
    add_request(skt_pkg::KIND_SEARCH, 32'h8000_0000, 32'h0000_0000);
    add_request(skt_pkg::KIND_SEARCH, 32'h1234_5678, 32'h0000_0000);
    add_request(KIND_UNUSED,          32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_request(skt_pkg::KIND_DELETE, 32'h7FFF_FFFF, 32'h0000_0000);
    add_request(skt_pkg::KIND_DELETE, 32'h7FFF_FFFF, 32'h0000_0000);
    add_request(skt_pkg::KIND_INSERT, 32'h0000_0001, 32'h0000_0001);
    add_request(skt_pkg::KIND_DELETE, 32'h0000_0000, 32'h0000_0000);
    add_request(skt_pkg::KIND_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
    add_request(skt_pkg::KIND_SEARCH, 32'h0000_0001, 32'hFFFF_FFFF);
    empty_table();

    // Signed keys over the whole range: fill past capacity, then a mixed load during
    // which the receiver's long hold falls.
    write_signed_cfg(1'b1);
    run_mix(360, 92, 4, 2, 1'b0);
    run_mix(220, 40, 30, 26, 1'b0);
    empty_table();

    // Clustered keys, first compared unsigned and then signed again.
    write_signed_cfg(1'b0);
    run_mix(250, 45, 25, 25, 1'b1);
    empty_table();
    write_signed_cfg(1'b1);
    run_mix(150, 45, 25, 25, 1'b1);
    empty_table();

    // Let any stray result show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_bad == 0 && due_answers.size() == 0) begin
      $display("sorted_key_table_top: match");
    end else begin
      $display("sorted_key_table_top: mismatch");
    end
    $finish;
  end

endmodule
